>>> design/mlr_pkg.sv
// shared types and constants for the midpoint line rasterizer
// no dependencies; imported by every module of the block
package mlr_pkg;

  localparam int COORD_BITS = 6;
  // decision variable stays within +/- twice the major span
  localparam int DW = COORD_BITS + 3;
  localparam int QDEPTH = 2;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);
  localparam logic [QAW-1:0] QPTR_LAST = QAW'(QDEPTH - 1);

  // one segment, already mirrored into the first octant
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         swap;   // y is the major axis
    logic                         s1neg;  // major axis steps down
    logic                         s2neg;  // minor axis steps down
    logic [COORD_BITS-1:0]        a;      // minor span
    logic [COORD_BITS-1:0]        b;      // major span, pixel count
  } cmd_t;

endpackage

>>> design/mlr_front.sv
// front end: accepts a segment and picks its octant
// depends on mlr_pkg; feeds mlr_queue
module mlr_front (
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [mlr_pkg::COORD_BITS-1:0]  start_x,
  input  logic signed [mlr_pkg::COORD_BITS-1:0]  start_y,
  input  logic signed [mlr_pkg::COORD_BITS-1:0]  end_x,
  input  logic signed [mlr_pkg::COORD_BITS-1:0]  end_y,
  input  logic                                   q_full,
  output logic                                   q_push,
  output mlr_pkg::cmd_t                          q_cmd
);
  import mlr_pkg::*;

  localparam int CW = COORD_BITS;

  logic signed [CW:0] dx;
  logic signed [CW:0] dy;
  logic signed [CW:0] ndx;
  logic signed [CW:0] ndy;
  logic signed [CW:0] maj;
  logic signed [CW:0] mnr;
  logic signed [CW:0] b_full;
  logic signed [CW:0] a_full;
  logic               swap;
  logic               s1neg;
  logic               s2neg;

  always_comb begin
    dx  = $signed({end_x[CW-1], end_x}) - $signed({start_x[CW-1], start_x});
    dy  = $signed({end_y[CW-1], end_y}) - $signed({start_y[CW-1], start_y});
    ndx = -dx;
    ndy = -dy;
  end

  // octant decode, same boundary order as the angle ranges
  always_comb begin
    swap  = 1'b0;
    s1neg = 1'b0;
    s2neg = 1'b0;
    if (dy >= 0 && dx > dy) begin
      swap = 1'b0;
    end else if (dx > 0 && dy >= dx) begin
      swap = 1'b1;
    end else if (dx <= 0 && dy > ndx) begin
      swap  = 1'b1;
      s2neg = 1'b1;
    end else if (dy > 0 && ndx >= dy) begin
      s1neg = 1'b1;
    end else if (dx < 0 && dy <= 0 && ndy <= ndx) begin
      s1neg = 1'b1;
      s2neg = 1'b1;
    end else if (dx <= 0 && ndy > ndx) begin
      swap  = 1'b1;
      s1neg = 1'b1;
      s2neg = 1'b1;
    end else if (dx > 0 && ndy >= dx) begin
      swap  = 1'b1;
      s1neg = 1'b1;
    end else if (dx > 0 && dy < 0) begin
      s2neg = 1'b1;
    end
  end

  always_comb begin
    maj    = swap ? dy : dx;
    mnr    = swap ? dx : dy;
    b_full = s1neg ? -maj : maj;
    a_full = s2neg ? -mnr : mnr;
  end

  always_comb begin
    q_cmd.x     = start_x;
    q_cmd.y     = start_y;
    q_cmd.swap  = swap;
    q_cmd.s1neg = s1neg;
    q_cmd.s2neg = s2neg;
    q_cmd.a     = a_full[CW-1:0];
    q_cmd.b     = b_full[CW-1:0];
  end

  // zero-length segments are taken and dropped here
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && (b_full[CW-1:0] != '0);

endmodule

>>> design/mlr_queue.sv
// short segment queue between front and back end
// depends on mlr_pkg
module mlr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mlr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output mlr_pkg::cmd_t q_cmd
);
  import mlr_pkg::*;

  cmd_t           slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full    = (count == (QAW+1)'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_LAST) ? '0 : wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_LAST) ? '0 : rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        count <= count + (QAW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QAW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH))
    else $error("queue count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

>>> design/mlr_back.sv
// back end: midpoint stepper, one pixel per beat into an output register
// depends on mlr_pkg; takes segments from mlr_queue
module mlr_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_valid,
  input  mlr_pkg::cmd_t                          q_cmd,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [mlr_pkg::COORD_BITS-1:0]  pixel_x,
  output logic signed [mlr_pkg::COORD_BITS-1:0]  pixel_y,
  output logic                                   last_pixel
);
  import mlr_pkg::*;

  localparam int CW = COORD_BITS;

  logic                   busy;
  logic signed [CW-1:0]   x;
  logic signed [CW-1:0]   y;
  logic [CW-1:0]          cnt;
  logic signed [DW-1:0]   d;
  logic signed [DW-1:0]   e;
  logic signed [DW-1:0]   ne;
  logic                   swap;
  logic                   s1neg;
  logic                   s2neg;

  logic                   emit;
  logic                   is_last;
  logic signed [CW-1:0]   x_next;
  logic signed [CW-1:0]   y_next;
  logic signed [DW-1:0]   d_next;
  logic signed [DW-1:0]   e_load;
  logic signed [DW-1:0]   b2_load;
  logic signed [DW-1:0]   b_load;
  logic signed [CW-1:0]   maj_step;
  logic signed [CW-1:0]   min_step;
  logic                   diag;

  assign emit    = busy && (!out_valid || !out_stall);
  assign q_pop   = !busy && q_valid;
  assign is_last = (cnt == COORD_ONE);

  always_comb begin
    e_load  = $signed({2'b00, q_cmd.a, 1'b0});
    b2_load = $signed({2'b00, q_cmd.b, 1'b0});
    b_load  = $signed({3'b000, q_cmd.b});
  end

  // step in the original frame: major axis every beat, minor on a diagonal
  always_comb begin
    diag     = (d > 0);
    maj_step = s1neg ? -$signed(COORD_ONE) : $signed(COORD_ONE);
    min_step = s2neg ? -$signed(COORD_ONE) : $signed(COORD_ONE);
    x_next   = x;
    y_next   = y;
    if (swap) begin
      y_next = y + maj_step;
      if (diag) begin
        x_next = x + min_step;
      end
    end else begin
      x_next = x + maj_step;
      if (diag) begin
        y_next = y + min_step;
      end
    end
    d_next = diag ? d + ne : d + e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end
      if (q_pop) begin
        busy <= 1'b1;
      end else if (emit && is_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x     <= q_cmd.x;
      y     <= q_cmd.y;
      cnt   <= q_cmd.b;
      swap  <= q_cmd.swap;
      s1neg <= q_cmd.s1neg;
      s2neg <= q_cmd.s2neg;
      e     <= e_load;
      ne    <= e_load - b2_load;
      d     <= e_load - b_load;
    end else if (emit) begin
      x   <= x_next;
      y   <= y_next;
      cnt <= cnt - COORD_ONE;
      d   <= d_next;
    end
    if (emit) begin
      pixel_x    <= x;
      pixel_y    <= y;
      last_pixel <= is_last;
    end
  end

  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0)
    else $error("stepper busy with no pixels left");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (emit && is_last) |=> !busy && out_valid && last_pixel)
    else $error("run did not end after its last pixel");

  a_emit_not_last: assert property (@(posedge clk) disable iff (rst)
    (emit && !is_last) |=> busy && out_valid && !last_pixel)
    else $error("run ended early");

endmodule

>>> design/midpoint_line_rasterizer_top.sv
// Midpoint line rasterizer. A segment beat (start_x, start_y, end_x, end_y) yields one pixel
// beat per major-axis step, from the start point up to but not including the end point, with
// last_pixel set on the final one; a zero-length segment yields nothing. A segment with major
// span N occupies the back-end stepper for a load step and then its N pixels, one per cycle as the
// output stalls allow. The front end classifies a segment in the cycle it arrives and parks it
// in a two-entry queue, so new segments are taken while a run is still being drawn. Zero-length
// segments are taken at the input and dropped. No reset-time clearing pass.
module midpoint_line_rasterizer_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [mlr_pkg::COORD_BITS-1:0]  start_x,
  input  logic signed [mlr_pkg::COORD_BITS-1:0]  start_y,
  input  logic signed [mlr_pkg::COORD_BITS-1:0]  end_x,
  input  logic signed [mlr_pkg::COORD_BITS-1:0]  end_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [mlr_pkg::COORD_BITS-1:0]  pixel_x,
  output logic signed [mlr_pkg::COORD_BITS-1:0]  pixel_y,
  output logic                                   last_pixel
);
  import mlr_pkg::*;

  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic push;
  logic full;
  logic pop;
  logic q_valid;

  mlr_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .q_full   (full),
    .q_push   (push),
    .q_cmd    (push_cmd)
  );

  mlr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (pop_cmd)
  );

  mlr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (pop_cmd),
    .q_pop      (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (last_pixel)
  );

endmodule

>>> test/midpoint_line_rasterizer_top_tb.sv
// self-checking testbench for midpoint_line_rasterizer_top
// predicts the pixel run of every accepted segment beat and compares the output beats in order
// depends on mlr_pkg (coordinate width) and the top-level ports
module midpoint_line_rasterizer_top_tb;

  localparam int CB = mlr_pkg::COORD_BITS;
  localparam int CMIN = -(1 << (CB - 1));
  localparam int CMAX = (1 << (CB - 1)) - 1;
  localparam int RANDOM_SEGS = 380;
  localparam int TAIL_CYCLES = 200;
  localparam longint TIMEOUT_CYCLES = 4_000_000;

  typedef struct {
    logic signed [CB-1:0] sx;
    logic signed [CB-1:0] sy;
    logic signed [CB-1:0] ex;
    logic signed [CB-1:0] ey;
    bit                   drain_first;
  } segment_t;

  typedef struct {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic                 last;
  } pixel_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CB-1:0] start_x = '0;
  logic signed [CB-1:0] start_y = '0;
  logic signed [CB-1:0] end_x = '0;
  logic signed [CB-1:0] end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CB-1:0] pixel_x;
  logic signed [CB-1:0] pixel_y;
  logic last_pixel;

  segment_t segments_pending[$];
  pixel_t   pixels_expected[$];
  int segs_total = 0;
  int segs_accepted = 0;
  int pixels_seen = 0;
  int mismatches = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit seg_taken = 1'b0;

  midpoint_line_rasterizer_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (last_pixel)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  function automatic int flip(input bit neg, input int v);
    return neg ? -v : v;
  endfunction

  // mirror into the first octant, step the major axis, map each pixel back
  function automatic void predict_pixels(input int sx, input int sy, input int ex, input int ey);
    int dx, dy, u, v, u_end, v_end, a, b, d;
    bit swap_ax, neg_major, neg_minor;
    pixel_t px;
    dx = ex - sx;
    dy = ey - sy;
    swap_ax = 1'b0;
    neg_major = 1'b0;
    neg_minor = 1'b0;
    // first octant and zero length keep the defaults
    if (dx > 0 && dy >= dx) begin
      swap_ax = 1'b1;
    end else if (dx <= 0 && dy > -dx) begin
      swap_ax = 1'b1;
      neg_minor = 1'b1;
    end else if (dy > 0 && -dx >= dy) begin
      neg_major = 1'b1;
    end else if (dx < 0 && dy <= 0 && -dy <= -dx) begin
      neg_major = 1'b1;
      neg_minor = 1'b1;
    end else if (dx <= 0 && -dy > -dx) begin
      swap_ax = 1'b1;
      neg_major = 1'b1;
      neg_minor = 1'b1;
    end else if (dx > 0 && -dy >= dx) begin
      swap_ax = 1'b1;
      neg_major = 1'b1;
    end else if (dx > 0 && dy < 0) begin
      neg_minor = 1'b1;
    end
    u     = flip(neg_major, swap_ax ? sy : sx);
    v     = flip(neg_minor, swap_ax ? sx : sy);
    u_end = flip(neg_major, swap_ax ? ey : ex);
    v_end = flip(neg_minor, swap_ax ? ex : ey);
    a = v_end - v;
    b = u_end - u;
    d = 2 * a - b;
    while (u < u_end) begin
      if (swap_ax) begin
        px.x = CB'(flip(neg_minor, v));
        px.y = CB'(flip(neg_major, u));
      end else begin
        px.x = CB'(flip(neg_major, u));
        px.y = CB'(flip(neg_minor, v));
      end
      px.last = (u + 1 == u_end);
      pixels_expected.insert(pixels_expected.size(), px);
      if (d > 0) begin
        v++;
        d += 2 * (a - b);
      end else begin
        d += 2 * a;
      end
      u++;
    end
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < CMIN) return CMIN;
    if (v > CMAX) return CMAX;
    return v;
  endfunction

  task automatic add_seg(input int sx, input int sy, input int ex, input int ey,
                         input bit drain_first);
    segment_t s;
    s.sx = CB'(sx);
    s.sy = CB'(sy);
    s.ex = CB'(ex);
    s.ey = CB'(ey);
    s.drain_first = drain_first;
    segments_pending.insert(segments_pending.size(), s);
    segs_total++;
  endtask

  task automatic add_random_seg(input bit drain_first);
    int sx, sy, ex, ey, r, len;
    r = $urandom_range(0, 99);
    sx = $urandom_range(0, CMAX - CMIN) + CMIN;
    sy = $urandom_range(0, CMAX - CMIN) + CMIN;
    if (r < 65) begin
      ex = $urandom_range(0, CMAX - CMIN) + CMIN;
      ey = $urandom_range(0, CMAX - CMIN) + CMIN;
    end else if (r < 82) begin
      ex = clamp_coord(sx + $urandom_range(0, 8) - 4);
      ey = clamp_coord(sy + $urandom_range(0, 8) - 4);
    end else if (r < 95) begin
      // axis-aligned and diagonal runs hit the octant boundaries
      len = $urandom_range(1, CMAX - CMIN);
      ex = clamp_coord(sx + len * ($urandom_range(0, 2) - 1));
      ey = clamp_coord(sy + len * ($urandom_range(0, 2) - 1));
    end else begin
      ex = sx;
      ey = sy;
    end
    add_seg(sx, sy, ex, ey, drain_first);
  endtask

  // segment driver
  always @(negedge clk) begin
    segment_t s;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || seg_taken) begin
      seg_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (segments_pending.size() == 0 ||
                   (segments_pending[0].drain_first && pixels_expected.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        s = segments_pending.pop_front();
        start_x <= s.sx;
        start_y <= s.sy;
        end_x <= s.ex;
        end_y <= s.ey;
        in_valid <= 1'b1;
        in_gap = pick_gap((segs_accepted / 50) % 4 == 1);
      end
    end
  end

  // pixel-side stall
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      out_gap = pick_gap((pixels_seen / 300) % 4 == 2);
    end
  end

  // segment beats feed the predictor, pixel beats are checked against it
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && in_valid && !in_stall) begin
      predict_pixels(start_x, start_y, end_x, end_y);
      seg_taken = 1'b1;
      segs_accepted++;
    end
    if (!rst && out_valid && !out_stall) begin
      if (pixels_expected.size() == 0) begin
        report_mismatch($sformatf("pixel (%0d,%0d) with nothing expected",
                                  pixel_x, pixel_y));
      end else begin
        want = pixels_expected.pop_front();
        if (pixel_x !== want.x)
          report_mismatch($sformatf("pixel %0d x: got %0d, expected %0d",
                                    pixels_seen, pixel_x, want.x));
        if (pixel_y !== want.y)
          report_mismatch($sformatf("pixel %0d y: got %0d, expected %0d",
                                    pixels_seen, pixel_y, want.y));
        if (last_pixel !== want.last)
          report_mismatch($sformatf("pixel %0d last_pixel: got %b, expected %b",
                                    pixels_seen, last_pixel, want.last));
      end
      pixels_seen++;
    end
  end

  initial begin
    // full-span diagonals and axes
    add_seg(CMIN, CMIN, CMAX, CMAX, 1'b0);
    add_seg(CMAX, CMAX, CMIN, CMIN, 1'b0);
    add_seg(CMIN, CMAX, CMAX, CMIN, 1'b0);
    add_seg(CMAX, CMIN, CMIN, CMAX, 1'b0);
    add_seg(CMIN, 0, CMAX, 0, 1'b0);
    add_seg(0, CMAX, 0, CMIN, 1'b0);
    // zero length, with a run queued right behind it
    add_seg(CMIN, CMIN, CMIN, CMIN, 1'b0);
    add_seg(CMAX, CMAX, CMAX, CMAX, 1'b0);
    add_seg(0, 0, 1, 0, 1'b0);
    // one segment inside each octant
    add_seg(0, 0, 7, 3, 1'b0);
    add_seg(0, 0, 3, 7, 1'b0);
    add_seg(0, 0, -3, 7, 1'b0);
    add_seg(0, 0, -7, 3, 1'b0);
    add_seg(0, 0, -7, -3, 1'b0);
    add_seg(0, 0, -3, -7, 1'b0);
    add_seg(0, 0, 3, -7, 1'b1);
    add_seg(0, 0, 7, -3, 1'b0);
    // octant boundaries: exact diagonals, the positive y axis and both negative axes
    add_seg(2, 2, 6, 6, 1'b0);
    add_seg(0, 0, 0, 5, 1'b0);
    add_seg(5, -5, 0, 0, 1'b0);
    add_seg(3, 1, -2, 1, 1'b0);
    add_seg(1, 1, -4, -4, 1'b0);
    add_seg(-1, 4, -1, -2, 1'b0);
    add_seg(-6, 6, -1, 1, 1'b0);
    for (int i = 0; i < RANDOM_SEGS; i++)
      add_random_seg(i == 120 || i == 260);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (segs_accepted != segs_total) @(posedge clk);
    while (pixels_expected.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pixels_expected.size() != 0)
      report_mismatch($sformatf("%0d pixels never arrived", pixels_expected.size()));

    if (mismatches == 0) begin
      $display("midpoint_line_rasterizer_top_tb passed");
    end else begin
      $display("midpoint_line_rasterizer_top_tb failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("midpoint_line_rasterizer_top_tb failed");
    $finish;
  end

endmodule

>>> sim.f
design/mlr_pkg.sv
design/mlr_front.sv
design/mlr_queue.sv
design/mlr_back.sv
design/midpoint_line_rasterizer_top.sv
test/midpoint_line_rasterizer_top_tb.sv
